[sv/fbpa_pkg.sv]
// fbpa_pkg: shared types, constants and codes for the fixed block pool allocator
// used by the allocator core, its link store and its checker
package fbpa_pkg;

    localparam int MAX_CHUNKS = 256;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int COUNT_W    = 9;
    localparam int SIZE_W     = 16;
    localparam int ADDR_W     = 32;
    localparam int PROD_W     = IDX_W + SIZE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
    localparam logic [COUNT_W-1:0] COUNT_CHUNKS   = COUNT_W'(MAX_CHUNKS);
    localparam logic [SIZE_W-1:0]  RESET_CHUNK_SZ = SIZE_W'(64);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ALLOC     = 2'd0,
        STATUS_FREED     = 2'd1,
        STATUS_TOO_LARGE = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS = 2'd0,
        CFG_CHUNK_SIZE   = 2'd1,
        CFG_NUM_CHUNKS   = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] request_size;
        logic [7:0]        free_index;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         chunk_index;
        logic [ADDR_W-1:0]  chunk_address;
        logic [COUNT_W-1:0] free_left;
    } rsp_t;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic              clear;
    } link_ctrl_t;

endpackage

[sv/fbpa_ram.sv]
// fbpa_ram: generic single-write, single-read ram with registered read data
// no dependencies
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/fbpa_link_store.sv]
// fbpa_link_store: next-link store of the free list, ram plus per-entry valid bits
// an entry never written since rebuild reads as its index plus one; uses fbpa_pkg, fbpa_ram
module fbpa_link_store
    import fbpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  link_ctrl_t        ctrl,
    output logic [LINK_W-1:0] rd_link
);

    logic [MAX_CHUNKS-1:0] valid_reg;
    logic [MAX_CHUNKS-1:0] valid_next;
    logic                  rd_valid_reg;
    logic [IDX_W-1:0]      rd_addr_reg;
    logic [LINK_W-1:0]     ram_rdata;

    fbpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_CHUNKS)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.wr_en),
        .waddr (ctrl.wr_addr),
        .wdata (ctrl.wr_data),
        .re    (ctrl.rd_en),
        .raddr (ctrl.rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = '0;
        end
        else if (ctrl.wr_en)
        begin
            valid_next[ctrl.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctrl.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_addr_reg <= ctrl.rd_addr;
        end
    end

    assign rd_link = rd_valid_reg ? ram_rdata : ({1'b0, rd_addr_reg} + LINK_W'(1));

endmodule

[sv/fixed_block_pool_allocator_core.sv]
// fixed_block_pool_allocator_core: lifo free-list allocator of equal-sized chunks
// uses fbpa_pkg and fbpa_link_store (which holds fbpa_ram)
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   req_t  (func, request_size, free_index)
//  rsp      out        rsp_valid/rsp_ready   rsp_t  (status, chunk_index, chunk_address, free_left)
//  cfg      in         cfg_we                cfg_index, cfg_data
//
// each transaction reads the head's next link from the link ram as it is taken, then in ST_EXEC
// updates head, count and link ram and loads the result register.
// a new transaction is taken once the previous one is done and the result slot is free
// or being emptied in that cycle; a stalled result holds in the output register.
// reset needs no clearing pass: per-entry valid bits give the rebuilt links at once.
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t             state_reg,     state_next;
    req_t               req_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [LINK_W-1:0]  head_reg,      head_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [ADDR_W-1:0]  base_reg,      base_next;
    logic [SIZE_W-1:0]  size_reg,      size_next;
    rsp_t               rsp_reg,       rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               req_fire;
    logic [IDX_W-1:0]   idx_sel;
    logic [LINK_W-1:0]  rd_link;
    logic [ADDR_W-1:0]  addr_sum;
    logic [COUNT_W-1:0] num_sat;
    link_ctrl_t         link_ctrl;

    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_fire  = req_valid && req_ready;
    assign idx_sel   = (req.func == FUNC_FREE) ? req.free_index : head_reg[IDX_W-1:0];
    assign addr_sum  = base_reg + ADDR_W'(prod_reg);
    assign num_sat   = (cfg_data[COUNT_W-1:0] > COUNT_CHUNKS) ? COUNT_CHUNKS
                                                               : cfg_data[COUNT_W-1:0];

    fbpa_link_store u_link_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (link_ctrl),
        .rd_link (rd_link)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        size_next      = size_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        link_ctrl         = '0;
        link_ctrl.rd_en   = req_fire;
        link_ctrl.rd_addr = head_reg[IDX_W-1:0];
        link_ctrl.wr_addr = req_reg.free_index;
        link_ctrl.wr_data = head_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next          = ST_IDLE;
                rsp_valid_next      = 1'b1;
                rsp_next.chunk_index   = '0;
                rsp_next.chunk_address = '0;
                if (req_reg.func == FUNC_FREE)
                begin
                    link_ctrl.wr_en        = 1'b1;
                    head_next              = {1'b0, req_reg.free_index};
                    count_next             = (count_reg < COUNT_MAX) ? count_reg + 1'b1
                                                                     : count_reg;
                    rsp_next.status        = STATUS_FREED;
                    rsp_next.chunk_index   = req_reg.free_index;
                    rsp_next.chunk_address = addr_sum;
                end
                else
                begin
                    priority if (req_reg.request_size > size_reg)
                    begin
                        rsp_next.status = STATUS_TOO_LARGE;
                    end
                    else if (count_reg == '0 || head_reg[LINK_W-1])
                    begin
                        rsp_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        head_next              = rd_link;
                        count_next             = count_reg - 1'b1;
                        rsp_next.status        = STATUS_ALLOC;
                        rsp_next.chunk_index   = head_reg[IDX_W-1:0];
                        rsp_next.chunk_address = addr_sum;
                    end
                end
                rsp_next.free_left = count_next;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BASE_ADDRESS: base_next = cfg_data[ADDR_W-1:0];
                CFG_CHUNK_SIZE:   size_next = cfg_data[SIZE_W-1:0];
                CFG_NUM_CHUNKS:
                begin
                    link_ctrl.clear = 1'b1;
                    head_next       = '0;
                    count_next      = num_sat;
                end
                CFG_UNUSED:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= COUNT_CHUNKS;
            base_reg      <= '0;
            size_reg      <= RESET_CHUNK_SZ;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            size_reg      <= size_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (req_fire)
        begin
            req_reg  <= req;
            prod_reg <= idx_sel * size_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[sv/fbpa_checker.sv]
// fbpa_checker: port-level assertions for fixed_block_pool_allocator_core
// uses fbpa_pkg; bound to the top level at the end of this file
module fbpa_checker
    import fbpa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    logic req_fire;
    assign req_fire = req_valid && req_ready;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    // one transaction at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready)
        else $error("req taken while busy");

    // a result follows each request, once its ST_EXEC state is done
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |-> ##2 rsp_valid)
        else $error("rsp missing after transaction");

    // errors carry no chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STATUS_TOO_LARGE || rsp.status == STATUS_EMPTY)
        |-> rsp.chunk_index == '0 && rsp.chunk_address == '0)
        else $error("error rsp with nonzero chunk");

    // freed chunk echoes the index of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.func == FUNC_FREE |-> ##2
        rsp.status == STATUS_FREED && rsp.chunk_index == $past(req.free_index, 2))
        else $error("free rsp mismatch");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
